// ===== hdl/kalman_const_velocity_tracker_unit_macros.svh =====
// Assertion macros shared by the tracker checker.
// No dependencies; include by bare file name.
`ifndef KALMAN_CONST_VELOCITY_TRACKER_UNIT_MACROS_SVH
`define KALMAN_CONST_VELOCITY_TRACKER_UNIT_MACROS_SVH

// clocked check, masked while reset is asserted
`define KCV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs through reset
`define KCV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/kcv_pkg.sv =====
// Shared constants, types and saturation helpers for the tracker.
// No dependencies.
package kcv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COV_W     = 48;
    localparam int WIDE_W    = 52;
    localparam int DIV_STEPS = DATA_W - 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int DVD_W     = COV_W + FRAC_BITS;
    localparam int PROD_W    = DATA_W + COV_W;
    localparam int MAG_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W     = COV_W + 1;

    localparam logic [DATA_W-1:0] PN_RESET = 32'd131072;
    localparam logic [DATA_W-1:0] MN_RESET = 32'd655360;

    typedef enum logic {
        CFG_PROCESS_NOISE = 1'b0,
        CFG_MEAS_NOISE    = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_FIRST, OP_PRED_A, OP_PRED_B, OP_PRED_C, OP_PRED_D,
        OP_DIV_INIT, OP_DIV_CHK, OP_DIV_STEP, OP_DIV_DONE,
        OP_MUL_SETUP, OP_MUL_LO, OP_MUL_HI, OP_MUL_SUM, OP_MUL_APPLY, OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        MUL_K0_INNOV, MUL_K1_INNOV, MUL_K0_PP, MUL_K0_PV, MUL_K1_PV
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FIRST, ST_PRED_A, ST_PRED_B, ST_PRED_C, ST_PRED_D,
        ST_DIV_INIT, ST_DIV_CHK, ST_DIV_STEP, ST_DIV_DONE,
        ST_MUL_SETUP, ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_MUL_APPLY, ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_sel;
        mul_sel_t mul_sel;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_full;
    } sts_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[WIDE_W-1]}}) begin
            return v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [COV_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1:COV_W-1] != {(WIDE_W-COV_W+1){v[WIDE_W-1]}}) begin
            return v[WIDE_W-1] ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
        end
        return v[COV_W-1:0];
    endfunction

endpackage

// ===== hdl/kcv_ctrl.sv =====
// Sequencer for predict, gain division and update of the tracker.
// Depends on kcv_pkg.
module kcv_ctrl import kcv_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t   state_reg, state_next;
    logic     primed_reg, primed_next;
    logic     div_sel_reg, div_sel_next;
    mul_sel_t mul_sel_reg, mul_sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            primed_reg  <= 1'b0;
            div_sel_reg <= 1'b0;
            mul_sel_reg <= MUL_K0_INNOV;
        end else begin
            state_reg   <= state_next;
            primed_reg  <= primed_next;
            div_sel_reg <= div_sel_next;
            mul_sel_reg <= mul_sel_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        primed_next  = primed_reg;
        div_sel_next = div_sel_reg;
        mul_sel_next = mul_sel_reg;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.div_sel  = div_sel_reg;
        cmd.mul_sel  = mul_sel_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = primed_reg ? ST_PRED_A : ST_FIRST;
                end
            end
            ST_FIRST: begin
                cmd.op      = OP_FIRST;
                primed_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PRED_A: begin
                cmd.op     = OP_PRED_A;
                state_next = ST_PRED_B;
            end
            ST_PRED_B: begin
                cmd.op     = OP_PRED_B;
                state_next = ST_PRED_C;
            end
            ST_PRED_C: begin
                cmd.op     = OP_PRED_C;
                state_next = ST_PRED_D;
            end
            ST_PRED_D: begin
                cmd.op       = OP_PRED_D;
                div_sel_next = 1'b0;
                state_next   = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                state_next = ST_DIV_CHK;
            end
            ST_DIV_CHK: begin
                cmd.op     = OP_DIV_CHK;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last) begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                cmd.op = OP_DIV_DONE;
                if (div_sel_reg) begin
                    mul_sel_next = MUL_K0_INNOV;
                    state_next   = ST_MUL_SETUP;
                end else begin
                    div_sel_next = 1'b1;
                    state_next   = ST_DIV_INIT;
                end
            end
            ST_MUL_SETUP: begin
                cmd.op     = OP_MUL_SETUP;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
                cmd.op     = OP_MUL_SUM;
                state_next = ST_MUL_APPLY;
            end
            ST_MUL_APPLY: begin
                cmd.op = OP_MUL_APPLY;
                if (mul_sel_reg == MUL_K1_PV) begin
                    state_next = ST_OUT;
                end else begin
                    mul_sel_next = mul_sel_t'(mul_sel_reg + 3'd1);
                    state_next   = ST_MUL_SETUP;
                end
            end
            ST_OUT: begin
                if (!sts.out_full) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/kcv_datapath.sv =====
// Tracker state, configuration registers, shared divider, multiplier and output register.
// Depends on kcv_pkg.
module kcv_datapath import kcv_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic signed [DATA_W-1:0] s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_filtered_position,
    output logic signed [DATA_W-1:0] m_velocity_estimate,
    output logic signed [DATA_W-1:0] m_predicted_position,
    input  cmd_t                     cmd,
    output sts_t                     sts
);

    localparam logic [MAG_W-1:0] LIM32 = MAG_W'(1) << (DATA_W - 1);
    localparam logic [MAG_W-1:0] LIM48 = MAG_W'(1) << (COV_W - 1);

    logic [DATA_W-1:0]        pn_reg, mn_reg;
    logic signed [DATA_W-1:0] pos_reg, vel_reg;
    logic signed [COV_W-1:0]  cov_pp_reg, cov_pv_reg, cov_vv_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] out_pos_reg, out_vel_reg, out_pred_reg;

    logic signed [DATA_W-1:0] z_reg, xp_reg, innov_reg, k0_reg, k1_reg;
    logic signed [WIDE_W-1:0] tmp_reg;
    logic signed [COV_W-1:0]  pp_reg, pv_reg, vv_reg;
    logic signed [SUM_W-1:0]  s_reg;
    logic [COV_W-1:0]         m_reg, rem_reg;
    logic                     neg_reg, ovf_reg;
    logic [DIV_STEPS-1:0]     dq_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DATA_W-1:0]        ma_reg;
    logic [COV_W-1:0]         mb_reg;
    logic                     mneg_reg;
    logic [2*DATA_W-1:0]      prod_reg, acc_reg;
    logic [MAG_W-1:0]         mag_reg;

    logic signed [COV_W-1:0]  div_num;
    logic [DVD_W-1:0]         dvd, dvd_hi;
    logic [COV_W:0]           rs, rs_diff;
    logic                     rs_ge, s_pos;
    logic signed [DATA_W-1:0] gain_next, mul_a;
    logic signed [COV_W-1:0]  mul_b;
    logic [DATA_W-1:0]        mul_op_b;
    logic [2*DATA_W-1:0]      prod_next;
    logic [PROD_W-1:0]        full;
    logic [MAG_W-1:0]         lim, mr_mag;
    logic signed [SUM_W-1:0]  mr;

    always_comb begin
        div_num = cmd.div_sel ? pv_reg : pp_reg;
        dvd     = {m_reg, {FRAC_BITS{1'b0}}};
        dvd_hi  = dvd >> DIV_STEPS;
        rs      = {rem_reg, dq_reg[DIV_STEPS-1]};
        rs_diff = rs - {1'b0, s_reg[COV_W-1:0]};
        rs_ge   = !rs_diff[COV_W];
        s_pos   = !s_reg[SUM_W-1] && (s_reg != '0);
        if (!s_pos) begin
            gain_next = '0;
        end else if (ovf_reg) begin
            gain_next = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            gain_next = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
        end

        mul_a = (cmd.mul_sel == MUL_K1_INNOV || cmd.mul_sel == MUL_K1_PV) ? k1_reg : k0_reg;
        case (cmd.mul_sel)
            MUL_K0_INNOV, MUL_K1_INNOV: mul_b = COV_W'(innov_reg);
            MUL_K0_PP:                  mul_b = pp_reg;
            default:                    mul_b = pv_reg;
        endcase
        mul_op_b  = (cmd.op == OP_MUL_HI) ? DATA_W'(mb_reg[COV_W-1:DATA_W]) : mb_reg[DATA_W-1:0];
        prod_next = ma_reg * mul_op_b;
        full      = PROD_W'(acc_reg) + (PROD_W'(prod_reg) << DATA_W);

        lim = (cmd.mul_sel == MUL_K0_INNOV || cmd.mul_sel == MUL_K1_INNOV) ? LIM32 : LIM48;
        if (mneg_reg) begin
            mr_mag = (mag_reg > lim) ? lim : mag_reg;
            mr     = -$signed(SUM_W'(mr_mag));
        end else begin
            mr_mag = (mag_reg > lim - 1'b1) ? lim - 1'b1 : mag_reg;
            mr     = $signed(SUM_W'(mr_mag));
        end
    end

    // configuration, tracker state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg      <= PN_RESET;
            mn_reg      <= MN_RESET;
            pos_reg     <= '0;
            vel_reg     <= '0;
            cov_pp_reg  <= '0;
            cov_pv_reg  <= '0;
            cov_vv_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_PROCESS_NOISE) begin
                    pn_reg <= cfg_data;
                end else begin
                    mn_reg <= cfg_data;
                end
            end
            if (cmd.op == OP_FIRST) begin
                pos_reg <= z_reg;
                vel_reg <= '0;
            end
            if (cmd.op == OP_MUL_APPLY) begin
                case (cmd.mul_sel)
                    MUL_K0_INNOV: pos_reg    <= sat32(WIDE_W'(xp_reg) + WIDE_W'(mr));
                    MUL_K1_INNOV: vel_reg    <= sat32(WIDE_W'(vel_reg) + WIDE_W'(mr));
                    MUL_K0_PP:    cov_pp_reg <= sat48(WIDE_W'(pp_reg) - WIDE_W'(mr));
                    MUL_K0_PV:    cov_pv_reg <= sat48(WIDE_W'(pv_reg) - WIDE_W'(mr));
                    default:      cov_vv_reg <= sat48(WIDE_W'(vv_reg) - WIDE_W'(mr));
                endcase
            end
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: z_reg <= s_sample;
            OP_PRED_A: begin
                xp_reg  <= sat32(WIDE_W'(pos_reg) + WIDE_W'(vel_reg));
                tmp_reg <= WIDE_W'(cov_pp_reg) + (WIDE_W'(cov_pv_reg) <<< 1);
                pv_reg  <= sat48(WIDE_W'(cov_pv_reg) + WIDE_W'(cov_vv_reg));
                vv_reg  <= sat48(WIDE_W'(cov_vv_reg) + WIDE_W'(pn_reg));
            end
            OP_PRED_B: begin
                tmp_reg   <= tmp_reg + WIDE_W'(cov_vv_reg);
                innov_reg <= sat32(WIDE_W'(z_reg) - WIDE_W'(xp_reg));
            end
            OP_PRED_C: pp_reg <= sat48(tmp_reg + WIDE_W'(pn_reg));
            OP_PRED_D: s_reg  <= SUM_W'(pp_reg) + SUM_W'(mn_reg);
            OP_DIV_INIT: begin
                neg_reg <= div_num[COV_W-1];
                m_reg   <= div_num[COV_W-1] ? COV_W'(-div_num) : div_num;
            end
            OP_DIV_CHK: begin
                ovf_reg <= dvd_hi >= DVD_W'(s_reg[COV_W-1:0]);
                rem_reg <= COV_W'(dvd_hi);
                dq_reg  <= dvd[DIV_STEPS-1:0];
                cnt_reg <= CNT_W'(DIV_STEPS - 1);
            end
            OP_DIV_STEP: begin
                rem_reg <= rs_ge ? rs_diff[COV_W-1:0] : rs[COV_W-1:0];
                dq_reg  <= {dq_reg[DIV_STEPS-2:0], rs_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_DIV_DONE: begin
                if (cmd.div_sel) begin
                    k1_reg <= gain_next;
                end else begin
                    k0_reg <= gain_next;
                end
            end
            OP_MUL_SETUP: begin
                ma_reg   <= mul_a[DATA_W-1] ? DATA_W'(-mul_a) : mul_a;
                mb_reg   <= mul_b[COV_W-1] ? COV_W'(-mul_b) : mul_b;
                mneg_reg <= mul_a[DATA_W-1] ^ mul_b[COV_W-1];
            end
            OP_MUL_LO: prod_reg <= prod_next;
            OP_MUL_HI: begin
                acc_reg  <= prod_reg;
                prod_reg <= prod_next;
            end
            OP_MUL_SUM: mag_reg <= MAG_W'(full >> FRAC_BITS);
            OP_OUT: begin
                out_pos_reg  <= pos_reg;
                out_vel_reg  <= vel_reg;
                out_pred_reg <= sat32(WIDE_W'(pos_reg) + WIDE_W'(vel_reg));
            end
            default: begin
            end
        endcase
    end

    assign sts.div_last         = (cnt_reg == '0);
    assign sts.out_full         = m_valid_reg && !m_ready;
    assign m_valid              = m_valid_reg;
    assign m_filtered_position  = out_pos_reg;
    assign m_velocity_estimate  = out_vel_reg;
    assign m_predicted_position = out_pred_reg;

endmodule

// ===== hdl/kalman_const_velocity_tracker_unit.sv =====
// Each sample but the first after reset gives one result beat, held while the result register is full.
// A new sample is taken only once the last is through the two 31-step restoring gain divisions
// and five two-pass products on one shared 32x32 multiplier.
// The first sample after reset only loads the position and gives no result.
// Reset (aresetn low, synchronous) clears state and covariance and reloads both noise registers.
module kalman_const_velocity_tracker_unit import kcv_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_filtered_position,
    output logic signed [DATA_W-1:0] m_velocity_estimate,
    output logic signed [DATA_W-1:0] m_predicted_position
);

    cmd_t cmd;
    sts_t sts;

    kcv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kcv_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_sample             (s_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_filtered_position  (m_filtered_position),
        .m_velocity_estimate  (m_velocity_estimate),
        .m_predicted_position (m_predicted_position),
        .cmd                  (cmd),
        .sts                  (sts)
    );

endmodule

// ===== hdl/kcv_checker.sv =====
// Port-level checks for the tracker, bound to the top level.
// Depends on kcv_pkg and kalman_const_velocity_tracker_unit_macros.svh.
`include "kalman_const_velocity_tracker_unit_macros.svh"

module kcv_checker import kcv_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_filtered_position,
    input logic signed [DATA_W-1:0] m_velocity_estimate,
    input logic signed [DATA_W-1:0] m_predicted_position
);

    `KCV_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_filtered_position) && $stable(m_predicted_position), "result beat changed while stalled")
    `KCV_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "sample taken while another is in work")
    `KCV_ASSERT(a_pred_sum, m_valid |-> m_predicted_position == sat32(WIDE_W'(m_filtered_position) + WIDE_W'(m_velocity_estimate)), "prediction is not position plus velocity")
    `KCV_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")

endmodule

bind kalman_const_velocity_tracker_unit kcv_checker u_kcv_checker (.*);

// ===== bench/kalman_const_velocity_tracker_unit_test.sv =====
// Self-checking bench for the two-state Kalman position/velocity tracker.
// Depends on kcv_pkg and kalman_const_velocity_tracker_unit; a scoreboard class
// predicts each estimate beat in fixed point and checks the beats that come out.
`timescale 1ns / 100ps

module kalman_const_velocity_tracker_unit_test;
    import kcv_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic                     cfg_index = 1'b0;
    logic [DATA_W-1:0]        cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_sample = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_filtered_position;
    logic signed [DATA_W-1:0] m_velocity_estimate;
    logic signed [DATA_W-1:0] m_predicted_position;

    int mismatches = 0;
    int s_idle = 0;
    int m_idle = 0;

    kalman_const_velocity_tracker_unit dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    typedef struct {
        logic signed [DATA_W-1:0] fpos;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] ppos;
    } estimate_t;

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    class tracker_scoreboard;
        longint pnoise, mnoise, pos, vel, cpp, cpv, cvv;
        bit primed;
        estimate_t pending_q[$];

        function new();
            pnoise = longint'(PN_RESET);
            mnoise = longint'(MN_RESET);
            pos = 0; vel = 0; cpp = 0; cpv = 0; cvv = 0;
            primed = 0;
        endfunction

        function void write_reg(logic idx, logic [DATA_W-1:0] val);
            if (idx == CFG_PROCESS_NOISE) pnoise = longint'(val);
            else mnoise = longint'(val);
        endfunction

        function longint clip(longint v, int w);
            longint hi, lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint qmul(longint a, longint b, int w);
            logic [127:0] ma, mb, r, lim;
            bit neg;
            neg = (a < 0) != (b < 0);
            ma = a < 0 ? 128'(-a) : 128'(a);
            mb = b < 0 ? 128'(-b) : 128'(b);
            r = (ma * mb) >> FRAC_BITS;
            lim = 128'd1 << (w - 1);
            if (neg) begin
                if (r > lim) r = lim;
                return -longint'(r);
            end
            if (r > lim - 1) r = lim - 1;
            return longint'(r);
        endfunction

        function longint qdiv(longint num, longint den);
            logic [127:0] m, q;
            m = num < 0 ? 128'(-num) : 128'(num);
            if (m / 128'(den) >= (128'd1 << (31 - FRAC_BITS)))
                return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
            q = (m << FRAC_BITS) / 128'(den);
            return num < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void note_sample(logic signed [DATA_W-1:0] z_in);
            longint z, xp, pp, pv, vv, s, k0, k1, innov;
            estimate_t e;
            z = longint'(z_in);
            if (!primed) begin
                pos = z; vel = 0; primed = 1;
                return;
            end
            xp = clip(pos + vel, 32);
            pp = clip(cpp + 2 * cpv + cvv + pnoise, 48);
            pv = clip(cpv + cvv, 48);
            vv = clip(cvv + pnoise, 48);
            s = pp + mnoise;
            k0 = 0; k1 = 0;
            if (s > 0) begin
                k0 = qdiv(pp, s);
                k1 = qdiv(pv, s);
            end
            innov = clip(z - xp, 32);
            pos = clip(xp + qmul(k0, innov, 32), 32);
            vel = clip(vel + qmul(k1, innov, 32), 32);
            cpp = clip(pp - qmul(k0, pp, 48), 48);
            cpv = clip(pv - qmul(k0, pv, 48), 48);
            cvv = clip(vv - qmul(k1, pv, 48), 48);
            e.fpos = pos[31:0];
            e.vel = vel[31:0];
            e.ppos = DATA_W'(clip(pos + vel, 32));
            pending_q.push_back(e);
        endfunction

        task check_estimate(logic signed [DATA_W-1:0] fp, logic signed [DATA_W-1:0] ve,
                            logic signed [DATA_W-1:0] pp);
            estimate_t e;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", fp, '0);
                return;
            end
            e = pending_q.pop_front();
            if (fp !== e.fpos) report_mismatch("filtered_position", fp, e.fpos);
            if (ve !== e.vel) report_mismatch("velocity_estimate", ve, e.vel);
            if (pp !== e.ppos) report_mismatch("predicted_position", pp, e.ppos);
        endtask
    endclass

    tracker_scoreboard sb = new();

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_estimate(m_filtered_position, m_velocity_estimate, m_predicted_position);
        m_ready <= ($urandom_range(99) >= m_idle);
    end

    task automatic send_sample(logic signed [DATA_W-1:0] z);
        while ($urandom_range(99) < s_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= z;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(z);
    endtask

    task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    longint trk_pos, trk_vel;

    function automatic logic signed [DATA_W-1:0] next_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            trk_pos = longint'($signed($urandom_range(65535) << 8));
            trk_vel = longint'($signed($urandom) >>> 14);
        end
        if (pick < 75) begin
            trk_pos = trk_pos + trk_vel;
            if (trk_pos > 64'sd2000000000 || trk_pos < -64'sd2000000000) trk_vel = -trk_vel;
            return DATA_W'(trk_pos + ($signed($urandom) >>> ($urandom_range(10, 20))));
        end
        if (pick < 92) return $urandom;
        case ($urandom_range(4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    initial begin
        #8_000_000;
        $display("FAIL kalman_const_velocity_tracker_unit");
        $finish;
    end

    initial begin
        logic signed [DATA_W-1:0] corners[] = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1,
            32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh00010000,
            32'shffff0000, 0, 32'sh55555555, 32'shaaaaaaaa, 32'sh40000000};
        trk_pos = 0;
        trk_vel = longint'(32'sh00008000);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: corners at reset noise, then extreme noise settings
        foreach (corners[i]) send_sample(corners[i]);
        drain();
        write_reg(CFG_PROCESS_NOISE, 32'd0);
        write_reg(CFG_MEAS_NOISE, 32'd1);
        foreach (corners[i]) if (i < 5) send_sample(corners[i]);
        drain();
        write_reg(CFG_PROCESS_NOISE, 32'hffffffff);
        write_reg(CFG_MEAS_NOISE, 32'd1);
        foreach (corners[i]) if (i < 5) send_sample(corners[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin s_idle = 28; m_idle = 87; end
                1: begin s_idle = 87; m_idle = 28; end
                default: begin s_idle = 0; m_idle = 0; end
            endcase
            case (ph)
                0: begin write_reg(CFG_PROCESS_NOISE, PN_RESET); write_reg(CFG_MEAS_NOISE, MN_RESET); end
                1: begin write_reg(CFG_PROCESS_NOISE, 32'd0); write_reg(CFG_MEAS_NOISE, 32'hffffffff); end
                2: begin write_reg(CFG_PROCESS_NOISE, 32'hffffffff); write_reg(CFG_MEAS_NOISE, 32'hffffffff); end
                3: begin write_reg(CFG_PROCESS_NOISE, 32'd0); write_reg(CFG_MEAS_NOISE, 32'd1); end
                default: begin
                    write_reg(CFG_PROCESS_NOISE, $urandom >> $urandom_range(31));
                    write_reg(CFG_MEAS_NOISE, ($urandom >> $urandom_range(31)) | 32'd1);
                end
            endcase
            repeat (300) send_sample(next_sample());
            drain();
        end

        if (mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASS kalman_const_velocity_tracker_unit");
        end else begin
            $display("FAIL kalman_const_velocity_tracker_unit");
        end
        $finish;
    end
endmodule

// ===== kalman_const_velocity_tracker_unit.f =====
+incdir+hdl
hdl/kcv_pkg.sv
hdl/kcv_ctrl.sv
hdl/kcv_datapath.sv
hdl/kalman_const_velocity_tracker_unit.sv
hdl/kcv_checker.sv
bench/kalman_const_velocity_tracker_unit_test.sv
